[src/bawb_pkg.sv]
// Shared types, codes and reset values for the buffer admission breaker.
package bawb_pkg;

  // Request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_VALIDATE = 2'd1;
  localparam logic [1:0] REQ_RESET    = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_PERMIT     = 4'd0;
  localparam logic [3:0] ST_NO_BUFFER  = 4'd1;
  localparam logic [3:0] ST_OPEN       = 4'd2;
  localparam logic [3:0] ST_PROTECTED  = 4'd3;
  localparam logic [3:0] ST_NO_CPU_RD  = 4'd4;
  localparam logic [3:0] ST_BAD_FORMAT = 4'd5;
  localparam logic [3:0] ST_BAD_GEOM   = 4'd6;
  localparam logic [3:0] ST_LOCK_FAIL  = 4'd7;
  localparam logic [3:0] ST_FAULT      = 4'd8;
  localparam logic [3:0] ST_TIMEOUT    = 4'd9;

  // Breaker modes
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT   = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  MAX_FAILURES_RST = 8'd3;
  localparam logic [15:0] COOLDOWN_RST     = 16'd10;
  localparam logic [31:0] TIMEOUT_RST      = 32'd2000000;
  localparam logic [63:0] SPAN_LIMIT_RST   = 64'hFFFF_FFFF_FFFF_FFFF;

  // Descriptor encodings
  localparam int unsigned USAGE_PROTECTED_BIT = 14;
  localparam logic [1:0]  USAGE_CPU_READ      = 2'b11;
  localparam logic [31:0] FMT_RGBA8           = 32'd1;
  localparam logic [31:0] FMT_RGBX8           = 32'd2;

  // Saturation limits and span width: (h-1)*s*4 + w*4 fits in 35 bits
  localparam logic [7:0]  FAIL_MAX = 8'hFF;
  localparam logic [15:0] AGE_MAX  = 16'hFFFF;
  localparam int unsigned SPAN_W   = 35;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        buf_present;
    logic [63:0] usage_flags;
    logic [31:0] pixel_format;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] row_stride;
    logic        probe_enable;
    logic        lock_ok;
    logic        probe_ok;
    logic [31:0] probe_latency;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [1:0] breaker_mode;
    logic [7:0] failure_run;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  trip_threshold;
    logic [15:0] cooldown_ticks;
    logic [31:0] latency_limit;
    logic [63:0] span_limit;
  } cfg_t;

  // Checked item handed from the descriptor stage to the breaker stage
  typedef struct packed {
    logic       valid;
    logic [1:0] req_type;
    logic       buf_present;
    logic [3:0] code;
  } chk_t;

endpackage

[src/bawb_chan_if.sv]
// Valid/ready channel carrying one payload item per transfer.
interface bawb_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/bawb_check.sv]
// Input register and descriptor/probe checks, independent of breaker state.
module bawb_check (
  input  logic            clk,
  input  logic            rst,
  bawb_chan_if.sink       req,
  input  bawb_pkg::cfg_t  cfg,
  output bawb_pkg::chk_t  chk,
  input  logic            chk_ready
);
  import bawb_pkg::*;

  logic              s1_valid;
  req_t              s1;
  logic [15:0]       h_m1;
  logic [31:0]       prod;
  logic [SPAN_W-1:0] span;
  logic              span_bad;
  logic [3:0]        code;

  assign req.ready = !s1_valid || chk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      s1 <= req.payload;
    end
  end

  // span = (h-1)*stride*4 + (w-1)*4 + 4; only meaningful once w, h > 0
  assign h_m1     = s1.img_height - 16'd1;
  assign prod     = {16'd0, h_m1} * {16'd0, s1.row_stride};
  assign span     = {1'b0, prod, 2'b00} + {17'd0, s1.img_width, 2'b00};
  assign span_bad = {{(64 - SPAN_W){1'b0}}, span} > cfg.span_limit;

  always_comb begin
    if (s1.usage_flags[USAGE_PROTECTED_BIT]) begin
      code = ST_PROTECTED;
    end else if (s1.usage_flags[1:0] != USAGE_CPU_READ) begin
      code = ST_NO_CPU_RD;
    end else if (s1.pixel_format != FMT_RGBA8 && s1.pixel_format != FMT_RGBX8) begin
      code = ST_BAD_FORMAT;
    end else if (s1.img_width == 16'd0 || s1.img_height == 16'd0 ||
                 s1.row_stride < s1.img_width || span_bad) begin
      code = ST_BAD_GEOM;
    end else if (s1.probe_enable && !s1.lock_ok) begin
      code = ST_LOCK_FAIL;
    end else if (s1.probe_enable && !s1.probe_ok) begin
      code = ST_FAULT;
    end else if (s1.probe_enable && s1.probe_latency > cfg.latency_limit) begin
      code = ST_TIMEOUT;
    end else begin
      code = ST_PERMIT;
    end
  end

  assign chk.valid       = s1_valid;
  assign chk.req_type    = s1.req_type;
  assign chk.buf_present = s1.buf_present;
  assign chk.code        = code;

endmodule

[src/bawb_breaker.sv]
// Breaker state update and result register.
module bawb_breaker (
  input  logic            clk,
  input  logic            rst,
  input  bawb_pkg::chk_t  chk,
  output logic            chk_ready,
  input  bawb_pkg::cfg_t  cfg,
  bawb_chan_if.source     rsp
);
  import bawb_pkg::*;

  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [7:0]  fail_count;
  logic [7:0]  fail_count_next;
  logic [15:0] trip_age;
  logic [15:0] trip_age_next;
  logic [1:0]  eff_mode;
  logic [7:0]  fail_inc;
  logic [3:0]  status;
  logic        out_valid;
  rsp_t        out_data;
  logic        take;

  assign chk_ready = !out_valid || rsp.ready;
  assign take      = chk.valid && chk_ready;

  assign eff_mode = (mode == MODE_OPEN) ? MODE_HALF : mode;
  assign fail_inc = (fail_count == FAIL_MAX) ? fail_count : fail_count + 8'd1;

  always_comb begin
    mode_next       = mode;
    fail_count_next = fail_count;
    trip_age_next   = trip_age;
    status          = ST_PERMIT;
    case (chk.req_type)
      REQ_TICK: begin
        if (trip_age != AGE_MAX) begin
          trip_age_next = trip_age + 16'd1;
        end
      end
      REQ_VALIDATE: begin
        if (!chk.buf_present) begin
          status = ST_NO_BUFFER;
        end else if (mode == MODE_OPEN && trip_age < cfg.cooldown_ticks) begin
          status = ST_OPEN;
        end else if (chk.code != ST_PERMIT) begin
          status    = chk.code;
          mode_next = eff_mode;
          if (eff_mode == MODE_HALF) begin
            mode_next     = MODE_OPEN;
            trip_age_next = 16'd0;
          end else if (eff_mode == MODE_CLOSED) begin
            fail_count_next = fail_inc;
            if (fail_inc >= cfg.trip_threshold) begin
              mode_next     = MODE_OPEN;
              trip_age_next = 16'd0;
            end
          end
        end else begin
          mode_next = eff_mode;
          if (eff_mode == MODE_HALF || eff_mode == MODE_CLOSED) begin
            mode_next       = MODE_CLOSED;
            fail_count_next = 8'd0;
          end
        end
      end
      REQ_RESET: begin
        mode_next       = MODE_CLOSED;
        fail_count_next = 8'd0;
        trip_age_next   = 16'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CLOSED;
      fail_count <= 8'd0;
      trip_age   <= 16'd0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        mode       <= mode_next;
        fail_count <= fail_count_next;
        trip_age   <= trip_age_next;
      end
      if (chk_ready) begin
        out_valid <= chk.valid;
      end
    end
    if (take) begin
      out_data.status       <= status;
      out_data.breaker_mode <= mode_next;
      out_data.failure_run  <= fail_count_next;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

endmodule

[src/buffer_admission_with_breaker.sv]
// Top level: image-buffer admission behind a closed/open/half-open breaker.
// A request passes the input register and then the result register before its
// result is offered. One request per cycle while the receiver keeps taking
// results; the span multiply, the checks and the breaker update all sit between
// the input register and the result register.
// Reset (rst, synchronous): breaker closed, failure run and trip age zero,
// config back to its defaults, both pipeline stages empty.
module buffer_admission_with_breaker (
  input  logic                             clk,
  input  logic                             rst,
  bawb_chan_if.sink                        req,
  bawb_chan_if.source                      rsp,
  input  logic                             cfg_we,
  input  logic [bawb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bawb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bawb_pkg::*;

  cfg_t cfg;
  chk_t chk;
  logic chk_ready;

  // Configuration registers; the user must write them only while the pipeline is
  // idle, so both stages see a stable value for every item; the block never checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_threshold <= MAX_FAILURES_RST;
      cfg.cooldown_ticks <= COOLDOWN_RST;
      cfg.latency_limit  <= TIMEOUT_RST;
      cfg.span_limit     <= SPAN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FAILURES: cfg.trip_threshold <= cfg_data[7:0];
        CFG_COOLDOWN:     cfg.cooldown_ticks <= cfg_data[15:0];
        CFG_TIMEOUT:      cfg.latency_limit  <= cfg_data[31:0];
        CFG_SPAN_LIMIT:   cfg.span_limit     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage 1: capture the request and run the descriptor and probe checks.
  // The outcome is boiled down to the first failing status code.
  bawb_check u_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .chk       (chk),
    .chk_ready (chk_ready)
  );

  // Stage 2: apply the check outcome to the breaker and register the result.
  // The result register frees stage 1 whenever it is empty or being drained.
  bawb_breaker u_breaker (
    .clk       (clk),
    .rst       (rst),
    .chk       (chk),
    .chk_ready (chk_ready),
    .cfg       (cfg),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  // A request refused by the open breaker leaves the breaker open.
  a_open_refusal: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status == ST_OPEN) |->
      (rsp.payload.breaker_mode == MODE_OPEN))
    else $error("open refusal reported with breaker not open");

  // A check failure that leaves the breaker closed must have counted.
  a_fail_counted: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status >= ST_PROTECTED &&
     rsp.payload.status <= ST_TIMEOUT &&
     rsp.payload.breaker_mode == MODE_CLOSED) |->
      (rsp.payload.failure_run != 8'd0))
    else $error("closed-state failure not counted");

  // A check failure never reports the half-open mode: it stays closed, trips or reopens.
  a_fail_not_half: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status >= ST_PROTECTED &&
     rsp.payload.status <= ST_TIMEOUT) |->
      (rsp.payload.breaker_mode != MODE_HALF))
    else $error("failure left breaker half-open");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the buffer admission breaker: directed table, then random phases.
module testbench;
  import bawb_pkg::*;

  // Request code 3 has no meaning in the block: it must leave all state alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Cycles without any transfer before the run is declared hung; the longest
  // legal quiet stretch is the forced receiver hold-off below
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    req_t item;
    bit   typed;  // expectation written into the table by hand
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bawb_chan_if #(.payload_t(req_t)) req_ch ();
  bawb_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  buffer_admission_with_breaker u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Breaker shadow: state and settings as the block should hold them
  // ---------------------------------------------------------------------
  logic [1:0]  brk_mode = MODE_CLOSED;
  logic [7:0]  fail_run = '0;
  logic [15:0] trip_age = '0;
  cfg_t        cur_cfg  = '{MAX_FAILURES_RST, COOLDOWN_RST, TIMEOUT_RST, SPAN_LIMIT_RST};

  rsp_t     admit_q[$];  // expected responses, oldest first
  dir_row_t dir_rows[$];
  int       err_count  = 0;
  bit       gap_on     = 1'b0;  // sender idles between items
  bit       hold_on    = 1'b0;  // receiver stalls between items
  int       stall_long = 0;     // one-shot long hold-off for the receiver
  int       quiet      = 0;

  // Any failure: half-open reopens; closed counts up (saturating) and
  // trips once the run reaches the trip threshold.
  function automatic void note_breaker_fail();
    if (brk_mode == MODE_HALF) begin
      brk_mode = MODE_OPEN;
      trip_age = '0;
    end else if (brk_mode == MODE_CLOSED) begin
      if (fail_run != FAIL_MAX) fail_run++;
      if (fail_run >= cur_cfg.trip_threshold) begin
        brk_mode = MODE_OPEN;
        trip_age = '0;
      end
    end
  endfunction

  // Validation path: descriptor checks in fixed order, then the probe.
  function automatic logic [3:0] judge_buffer(input req_t r);
    logic [63:0] ww, hh, ss, span;
    logic [3:0]  code;
    if (!r.buf_present) return ST_NO_BUFFER;
    if (brk_mode == MODE_OPEN) begin
      if (trip_age >= cur_cfg.cooldown_ticks) brk_mode = MODE_HALF;
      else return ST_OPEN;
    end
    ww = 64'(r.img_width);
    hh = 64'(r.img_height);
    ss = 64'(r.row_stride);
    // only meaningful once geometry is non-degenerate
    span = (hh - 64'd1) * ss * 64'd4 + (ww - 64'd1) * 64'd4 + 64'd4;
    if (r.usage_flags[USAGE_PROTECTED_BIT])                       code = ST_PROTECTED;
    else if (r.usage_flags[1:0] != USAGE_CPU_READ)                code = ST_NO_CPU_RD;
    else if (r.pixel_format != FMT_RGBA8 && r.pixel_format != FMT_RGBX8)
                                                                  code = ST_BAD_FORMAT;
    else if (ww == 0 || hh == 0 || ss < ww)                       code = ST_BAD_GEOM;
    else if (span > cur_cfg.span_limit)                           code = ST_BAD_GEOM;
    else if (r.probe_enable && !r.lock_ok)                        code = ST_LOCK_FAIL;
    else if (r.probe_enable && !r.probe_ok)                       code = ST_FAULT;
    else if (r.probe_enable && r.probe_latency > cur_cfg.latency_limit) code = ST_TIMEOUT;
    else                                                          code = ST_PERMIT;
    if (code == ST_PERMIT) begin
      brk_mode = MODE_CLOSED;
      fail_run = '0;
    end else begin
      note_breaker_fail();
    end
    return code;
  endfunction

  function automatic rsp_t predict_admission(input req_t r);
    rsp_t o;
    o.status = ST_PERMIT;
    case (r.req_type)
      REQ_TICK:     if (trip_age != AGE_MAX) trip_age++;
      REQ_VALIDATE: o.status = judge_buffer(r);
      REQ_RESET: begin
        brk_mode = MODE_CLOSED;
        fail_run = '0;
        trip_age = '0;
      end
      default: ;
    endcase
    o.breaker_mode = brk_mode;
    o.failure_run  = fail_run;
    return o;
  endfunction

  function automatic rsp_t outcome(input logic [3:0] s, input logic [1:0] m,
                                   input logic [7:0] n);
    rsp_t o;
    o.status       = s;
    o.breaker_mode = m;
    o.failure_run  = n;
    return o;
  endfunction

  function automatic void add_row(input req_t item, input bit typed, input rsp_t want);
    dir_row_t row;
    row.item  = item;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Validations with random content and well-formed descriptors, half of them with
  // one broken descriptor field, plus ticks, breaker resets and pure noise.
  function automatic req_t draw_request();
    req_t r;
    int   kind;
    r.req_type      = REQ_VALIDATE;
    r.buf_present   = 1'b1;
    r.usage_flags   = {$urandom, $urandom};
    r.pixel_format  = $urandom;
    r.img_width     = 16'($urandom);
    r.img_height    = 16'($urandom);
    r.row_stride    = 16'($urandom);
    r.probe_enable  = 1'($urandom);
    r.lock_ok       = 1'($urandom);
    r.probe_ok      = 1'($urandom);
    r.probe_latency = $urandom;
    kind = $urandom_range(0, 99);
    if (kind < 20)      r.req_type = REQ_TICK;
    else if (kind < 27) r.req_type = REQ_RESET;
    else if (kind < 30) r.req_type = REQ_UNUSED;
    if (kind < 30 || kind >= 92) begin
      r.buf_present = 1'($urandom);
      return r;
    end
    r.usage_flags[USAGE_PROTECTED_BIT] = 1'b0;
    r.usage_flags[1:0] = USAGE_CPU_READ;
    r.pixel_format = $urandom_range(0, 1) ? FMT_RGBA8 : FMT_RGBX8;
    if ($urandom_range(0, 15) == 0) begin
      r.img_width  = 16'($urandom_range(1, 65535));
      r.img_height = 16'($urandom_range(1, 65535));
      r.row_stride = 16'($urandom_range(65535, r.img_width));
    end else begin
      r.img_width  = 16'($urandom_range(1, 64));
      r.img_height = 16'($urandom_range(1, 64));
      r.row_stride = r.img_width + 16'($urandom_range(0, 16));
    end
    r.lock_ok  = ($urandom_range(0, 7) != 0);
    r.probe_ok = ($urandom_range(0, 7) != 0);
    // latency right around the threshold most of the time
    case ($urandom_range(0, 2))
      0:       r.probe_latency = cur_cfg.latency_limit - 32'($urandom_range(0, 3));
      1:       r.probe_latency = cur_cfg.latency_limit + 32'($urandom_range(0, 3));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: r.buf_present = 1'b0;
      1: r.usage_flags[USAGE_PROTECTED_BIT] = 1'b1;
      2: r.usage_flags[$urandom_range(0, 1)] = 1'b0;
      3: r.pixel_format = $urandom;
      4: begin
        case ($urandom_range(0, 2))
          0:       r.img_width = '0;
          1:       r.img_height = '0;
          default: r.row_stride = r.img_width - 16'd1;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (admit_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected response status %0d", got.status));
      return;
    end
    want = admit_q.pop_front();
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.breaker_mode !== want.breaker_mode)
      flag_mismatch($sformatf("breaker_mode %0d, want %0d", got.breaker_mode,
                              want.breaker_mode));
    if (got.failure_run !== want.failure_run)
      flag_mismatch($sformatf("failure_run %0d, want %0d", got.failure_run,
                              want.failure_run));
  endtask

  // Offer one request; returns at the edge of its transfer with valid still
  // high so a back-to-back item needs no second assignment in that step.
  task automatic send_req(input req_t item, input bit typed, input rsp_t want);
    int   gap;
    rsp_t pred;
    gap = gap_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // the shadow always advances, even when the table supplies the answer
    pred = predict_admission(item);
    admit_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    while (admit_q.size() != 0) @(posedge clk);
  endtask

  // Write all four registers back to back; the block is idle here.
  task automatic load_settings(input cfg_t c);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      case (i)
        0: begin cfg_index <= CFG_MAX_FAILURES; cfg_data <= 64'(c.trip_threshold); end
        1: begin cfg_index <= CFG_COOLDOWN;     cfg_data <= 64'(c.cooldown_ticks); end
        2: begin cfg_index <= CFG_TIMEOUT;      cfg_data <= 64'(c.latency_limit);  end
        default: begin cfg_index <= CFG_SPAN_LIMIT; cfg_data <= c.span_limit;    end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
    @(posedge clk);
  endtask

  // Random stretch; with_pause makes the sender stop once mid-phase until
  // every outstanding response has come back.
  task automatic run_random(input int count, input bit with_pause);
    int pause_at;
    pause_at = with_pause ? $urandom_range(0, count - 2) : -1;
    for (int n = 0; n < count; n++) begin
      send_req(draw_request(), 1'b0, '0);
      if (n == pause_at) begin
        req_ch.valid <= 1'b0;
        drain();
      end
    end
    req_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input cfg_t c, input int count, input bit gaps,
                           input bit holds, input bit with_pause);
    drain();
    load_settings(c);
    gap_on  = gaps;
    hold_on = holds;
    run_random(count, with_pause);
  endtask

  // ---------------------------------------------------------------------
  // Response side: random stall per item, plus the one forced long hold-off
  // ---------------------------------------------------------------------
  initial begin : rsp_side
    int hold;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      hold = hold_on ? $urandom_range(0, 12) : 0;
      if (stall_long > 0) begin
        hold = stall_long;
        stall_long = 0;
      end
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      check_result(rsp_ch.payload);
    end
  end

  // Hang detector: any transfer on either channel resets the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    req_t base, r;
    cfg_t c;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_MAX_FAILURES;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Clean RGBA8 4x4 descriptor, probe off; rows below bend one thing each
    base = '0;
    base.req_type     = REQ_VALIDATE;
    base.buf_present  = 1'b1;
    base.usage_flags  = 64'(USAGE_CPU_READ);
    base.pixel_format = FMT_RGBA8;
    base.img_width    = 16'd4;
    base.img_height   = 16'd4;
    base.row_stride   = 16'd4;
    base.lock_ok      = 1'b1;
    base.probe_ok     = 1'b1;

    // Directed table, reset settings: fail threshold 3, cooldown 10
    r = base; r.req_type = REQ_TICK;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    r = base; r.req_type = REQ_UNUSED;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    // missing buffer outranks every other field, all ones here
    r = '1; r.req_type = REQ_VALIDATE; r.buf_present = 1'b0;
    add_row(r, 1'b1, outcome(ST_NO_BUFFER, MODE_CLOSED, 8'd0));
    // largest geometry, latency exactly at the threshold
    r = base; r.pixel_format = FMT_RGBX8; r.img_width = '1; r.img_height = '1;
    r.row_stride = '1; r.probe_enable = 1'b1; r.probe_latency = TIMEOUT_RST;
    add_row(r, 1'b0, '0);
    r = base; r.usage_flags = '1;
    add_row(r, 1'b1, outcome(ST_PROTECTED, MODE_CLOSED, 8'd1));
    r = base; r.usage_flags = 64'h1;
    add_row(r, 1'b1, outcome(ST_NO_CPU_RD, MODE_CLOSED, 8'd2));
    // probe off: bad outcomes are ignored, success clears the run
    r = base; r.lock_ok = 1'b0; r.probe_ok = 1'b0; r.probe_latency = '1;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    r = base; r.pixel_format = '0;
    add_row(r, 1'b1, outcome(ST_BAD_FORMAT, MODE_CLOSED, 8'd1));
    r = base; r.pixel_format = 32'd3;
    add_row(r, 1'b1, outcome(ST_BAD_FORMAT, MODE_CLOSED, 8'd2));
    r = base; r.req_type = REQ_RESET;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    r = base; r.img_width = '0;
    add_row(r, 1'b1, outcome(ST_BAD_GEOM, MODE_CLOSED, 8'd1));
    r = base; r.img_height = '0;
    add_row(r, 1'b1, outcome(ST_BAD_GEOM, MODE_CLOSED, 8'd2));
    r = base; r.req_type = REQ_RESET;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    r = base; r.img_width = 16'd5;
    add_row(r, 1'b1, outcome(ST_BAD_GEOM, MODE_CLOSED, 8'd1));
    r = base; r.probe_enable = 1'b1; r.lock_ok = 1'b0;
    add_row(r, 1'b1, outcome(ST_LOCK_FAIL, MODE_CLOSED, 8'd2));
    r = base; r.req_type = REQ_RESET;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    r = base; r.probe_enable = 1'b1; r.probe_ok = 1'b0;
    add_row(r, 1'b1, outcome(ST_FAULT, MODE_CLOSED, 8'd1));
    r = base; r.probe_enable = 1'b1; r.probe_latency = TIMEOUT_RST + 32'd1;
    add_row(r, 1'b1, outcome(ST_TIMEOUT, MODE_CLOSED, 8'd2));
    add_row(base, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));
    // three failures in a row trip the breaker; the trip keeps the count
    r = base; r.pixel_format = '0;
    add_row(r, 1'b1, outcome(ST_BAD_FORMAT, MODE_CLOSED, 8'd1));
    add_row(r, 1'b1, outcome(ST_BAD_FORMAT, MODE_CLOSED, 8'd2));
    add_row(r, 1'b1, outcome(ST_BAD_FORMAT, MODE_OPEN, 8'd3));
    add_row(base, 1'b1, outcome(ST_OPEN, MODE_OPEN, 8'd3));
    r = base; r.buf_present = 1'b0;
    add_row(r, 1'b1, outcome(ST_NO_BUFFER, MODE_OPEN, 8'd3));
    r = base; r.req_type = REQ_TICK;
    add_row(r, 1'b0, '0);
    r = base; r.req_type = REQ_RESET;
    add_row(r, 1'b1, outcome(ST_PERMIT, MODE_CLOSED, 8'd0));

    gap_on  = 1'b1;
    hold_on = 1'b1;
    foreach (dir_rows[i]) send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random under reset settings; half-open arrives after ten ticks
    run_random(250, 1'b1);

    // Low extremes, back to back from the sender: the receiver holds off
    // long enough for the pipeline to fill and push back on requests
    c = '{8'd1, 16'd0, 32'd0, 64'd0};
    drain();
    load_settings(c);
    gap_on     = 1'b0;
    hold_on    = 1'b1;
    stall_long = LONG_HOLD;
    run_random(150, 1'b0);

    // High extremes: long fail run before a trip, open stays open
    c = '{FAIL_MAX, AGE_MAX, 32'hFFFF_FFFF, SPAN_LIMIT_RST};
    run_phase(c, 150, 1'b1, 1'b1, 1'b1);

    // Cooldown edge: one failure trips, then ticks up to one short of the cooldown
    c = '{8'd1, 16'd40, TIMEOUT_RST, SPAN_LIMIT_RST};
    drain();
    load_settings(c);
    gap_on  = 1'b0;
    hold_on = 1'b0;
    r = base; r.req_type = REQ_RESET;
    send_req(r, 1'b0, '0);
    r = base; r.pixel_format = '0;
    send_req(r, 1'b0, '0);
    r = base; r.req_type = REQ_TICK;
    repeat (int'(c.cooldown_ticks) - 1) send_req(r, 1'b0, '0);
    send_req(base, 1'b0, '0);      // one tick short: still refused
    repeat (5) send_req(r, 1'b0, '0);  // past the cooldown
    send_req(base, 1'b0, '0);      // half-open pass, closes
    req_ch.valid <= 1'b0;

    // Zero threshold: every failure trips at once
    c.trip_threshold = 8'd0;
    c.cooldown_ticks = 16'd2;
    c.latency_limit  = $urandom;
    c.span_limit     = 64'($urandom_range(0, 30000));
    run_phase(c, 150, 1'b1, 1'b0, 1'b0);

    // Random settings around the interesting thresholds
    repeat (4) begin
      c.trip_threshold = 8'($urandom_range(1, 6));
      c.cooldown_ticks = 16'($urandom_range(0, 12));
      c.latency_limit  = $urandom;
      c.span_limit     = ($urandom_range(0, 3) == 0) ? SPAN_LIMIT_RST
                                                     : 64'($urandom_range(0, 30000));
      run_phase(c, 175, 1'($urandom), 1'($urandom), 1'b1);
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[buffer_admission_with_breaker.f]
src/bawb_pkg.sv
src/bawb_chan_if.sv
src/bawb_check.sv
src/bawb_breaker.sv
src/buffer_admission_with_breaker.sv
tb/testbench.sv
